FILE: design/cqrb_pkg.sv
package cqrb_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_SIZE    = 2'd2,
    ACT_DISPLAY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    action_t                   action;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage

FILE: design/cqrb_front.sv
module cqrb_front
  import cqrb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic signed [DATA_W-1:0]  in_value,
  output logic                      push_valid,
  input  logic                      push_ready,
  output cmd_t                      push_cmd
);

  logic vld_r;
  logic vld_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    vld_nxt        = vld_r && !push_ready;
    cmd_nxt        = cmd_r;
    if (in_valid && in_ready) begin
      vld_nxt        = 1'b1;
      cmd_nxt.action = action_t'(in_action);
      // value only matters to an insert
      cmd_nxt.value  = (action_t'(in_action) == ACT_INSERT) ? in_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

FILE: design/cqrb_cmdq.sv
module cqrb_cmdq
  import cqrb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] w;
    w = {1'b0, p} + (PTR_W+1)'(1);
    return (w == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : w[PTR_W-1:0];
  endfunction

  assign push_ready = (fill_r != FILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = entry_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (do_push) wptr_r <= ptr_inc(wptr_r);
      if (do_pop)  rptr_r <= ptr_inc(rptr_r);
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + FILL_W'(1);
        2'b01:   fill_r <= fill_r - FILL_W'(1);
        default: fill_r <= fill_r;
      endcase
    end
    if (do_push) entry_r[wptr_r] <= push_cmd;
  end

endmodule

FILE: design/cqrb_back.sv
module cqrb_back
  import cqrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_wr_data,
  input  logic                      cmd_valid,
  output logic                      cmd_pop,
  input  cmd_t                      cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [CNT_W-1:0]          out_count,
  output logic signed [DATA_W-1:0]  out_data,
  output logic                      out_last
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW      = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int CAP_MAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

  typedef enum logic {S_EXEC, S_DISP} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic [DATA_W-1:0]  slots [DEPTH];
  logic [DATA_W-1:0]  rd_data_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic               out_free;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p,
                                               input logic [CNT_W-1:0] c);
    logic [WW-1:0] w;
    w = WW'(p) + WW'(1);
    return (w == WW'(c)) ? '0 : w[IDX_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cap_clamp(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (r == '0) r = CNT_W'(1);
    if (r > CNT_W'(CAP_MAX)) r = CNT_W'(CAP_MAX);
    return r;
  endfunction

  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    held_nxt       = held_r;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    cmd_pop        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    wr_en          = 1'b0;

    unique case (state_r)
      S_EXEC: begin
        if (cmd_valid && out_free) begin
          cmd_pop        = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
          unique case (cmd.action)
            ACT_INSERT: begin
              if (held_r >= cap_r) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = ptr_inc(tail_r, cap_r);
                held_nxt = held_r + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              if (held_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (held_r == CNT_W'(1)) begin
                held_nxt = '0;
                head_nxt = '0;
                tail_nxt = '0;
              end else begin
                held_nxt = held_r - CNT_W'(1);
                head_nxt = ptr_inc(head_r, cap_r);
              end
            end
            ACT_SIZE: begin
              if (held_r == '0) out_status_nxt = ST_EMPTY;
            end
            ACT_DISPLAY: begin
              if (held_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // first entry is fetched now, streamed from S_DISP
                out_valid_nxt = out_valid_r && !out_ready;
                rd_en         = 1'b1;
                rd_addr       = head_r;
                pos_nxt       = head_r;
                rem_nxt       = held_r;
                state_nxt     = S_DISP;
              end
            end
            default: ;
          endcase
          out_count_nxt = held_nxt;
        end
      end
      S_DISP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_count_nxt  = held_r;
          out_data_nxt   = rd_data_r;
          out_last_nxt   = (rem_r == CNT_W'(1));
          pos_nxt        = ptr_inc(pos_r, cap_r);
          rem_nxt        = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_EXEC;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_nxt;
          end
        end
      end
      default: state_nxt = S_EXEC;
    endcase

    if (cfg_wr_en) begin
      cap_nxt  = cap_clamp(cfg_wr_data);
      head_nxt = '0;
      tail_nxt = '0;
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      cap_r       <= CNT_W'(CAP_MAX);
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[tail_r] <= cmd.value;
    if (rd_en) rd_data_r <= slots[rd_addr];
  end

  a_held_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cap_r)
    else $error("held count above capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == '0 |-> head_r == '0 && tail_r == '0)
    else $error("empty queue with pointers off slot zero");

  a_disp_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DISP |-> !cmd_pop && rem_r != '0 && rem_r <= held_r)
    else $error("display stream state inconsistent");

  a_disp_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DISP && out_free && rem_r == CNT_W'(1) |=>
      state_r == S_EXEC && out_valid_r && out_last_r)
    else $error("display did not close with last");

endmodule

FILE: design/circular_queue_ring_buffer_core.sv
// Circular queue over a ring of DEPTH 32-bit slots, capacity set by cfg_wr_data
// (0 taken as 1, clamped to the smaller of DEPTH and 16; any write empties the
// queue). Insert, delete and size each give one result and are executed at one
// item per cycle when out_ready is high; a display of n entries gives n results,
// one per cycle while out_ready is high, once the first slot has been fetched
// from the ring memory, and holds further items in the two-entry command queue
// meanwhile. Each transfer in passes through the front register and then the
// command queue before the back end executes it.
module circular_queue_ring_buffer_core
  import cqrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic signed [DATA_W-1:0]  in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [CNT_W-1:0]          out_count,
  output logic signed [DATA_W-1:0]  out_data,
  output logic                      out_last
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  cqrb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  cqrb_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (cmd_valid),
    .pop        (cmd_pop),
    .pop_cmd    (cmd)
  );

  cqrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_count   (out_count),
    .out_data    (out_data),
    .out_last    (out_last)
  );

endmodule
